@@ rtl/pau_pkg.sv @@
package pau_pkg;

  localparam int ARCHIVE_DEPTH_DEF = 32;
  localparam int SIZE_BITS_DEF     = 12;

  localparam int ERR_W    = 16;
  localparam int SIZE_W   = 12;
  localparam int IDX_W    = 5;
  localparam int OCNT_W   = 6;

  // slave tdata layout
  localparam int S_ERR_LSB  = 0;
  localparam int S_SIZE_LSB = S_ERR_LSB + ERR_W;
  localparam int S_IDX_LSB  = S_SIZE_LSB + SIZE_W;
  localparam int S_TDATA_W  = ((S_IDX_LSB + IDX_W + 7) / 8) * 8;

  // master tdata layout
  localparam int M_ACC_LSB   = 0;
  localparam int M_REM_LSB   = M_ACC_LSB + 1;
  localparam int M_CHG_LSB   = M_REM_LSB + OCNT_W;
  localparam int M_OVF_LSB   = M_CHG_LSB + 1;
  localparam int M_CNT_LSB   = M_OVF_LSB + 1;
  localparam int M_RVAL_LSB  = M_CNT_LSB + OCNT_W;
  localparam int M_RERR_LSB  = M_RVAL_LSB + 1;
  localparam int M_RSIZE_LSB = M_RERR_LSB + ERR_W;
  localparam int M_TDATA_W   = ((M_RSIZE_LSB + SIZE_W + 7) / 8) * 8;

  typedef enum logic {
    REQ_OFFER = 1'b0,
    REQ_READ  = 1'b1
  } pau_req_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_SCAN,
    ST_COMPACT,
    ST_FIN
  } pau_state_e;

  // eq: same point, rm: candidate beats entry, rej: entry equals or beats candidate
  typedef struct packed {
    logic eq;
    logic rm;
    logic rej;
  } pau_cmp_t;

endpackage

@@ rtl/pareto_archive_update.sv @@
// channel  dir  tdata (lsb first)                                  tuser
// s_axis   in   cand_error, cand_size, read_index, zero pad         req_type
// m_axis   out  accepted, removed_count, archive_changed, overflow,  -
//               entry_count, read_valid, read_error, read_size, pad
//
// read: the archive memory is read in ST_RD and the result is registered in ST_FIN
// offer: straight to the finish step on an empty archive; otherwise a scan of the
//   entries, newest first, up to the rejecting one, then a compaction of the entries
//   above the rejecting one (or all if none rejects) when there are any, then the
//   finish step; the single read port of the archive memory feeds one compare
//   unit, first for the scan and then for the compaction
// one transaction at a time; s_axis_tready_o is high only when idle
// a finished result sits in the output register while the next one is taken;
//   the finish step waits while that register still holds an untaken result
// reset clears the entry count; the archive memory needs no clearing pass
module pareto_archive_update
  import pau_pkg::*;
#(
  parameter int ARCHIVE_DEPTH = ARCHIVE_DEPTH_DEF,
  parameter int SIZE_BITS     = SIZE_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // cand_error, cand_size, read_index, zero pad
  input  logic [S_TDATA_W-1:0] s_axis_tdata_i,
  // req_type
  input  logic                 s_axis_tuser_i,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // accepted, removed_count, archive_changed, overflow, entry_count,
  // read_valid, read_error, read_size, zero pad
  output logic [M_TDATA_W-1:0] m_axis_tdata_o
);

  localparam int AW = $clog2(ARCHIVE_DEPTH);
  localparam int CW = $clog2(ARCHIVE_DEPTH + 1);
  localparam int XW = (CW > IDX_W) ? CW : IDX_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(ARCHIVE_DEPTH);

  pau_state_e state_q, state_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic                 iss_q, iss_d;
  logic                 pend_q, pend_d;
  logic                 stop_q, stop_d;
  logic                 m_valid_q, m_valid_d;
  logic [AW-1:0]        addr_q, addr_d;
  logic [AW-1:0]        idx_q, idx_d;
  logic [AW-1:0]        wr_q, wr_d;
  logic [CW-1:0]        rem_q, rem_d;
  pau_req_e             req_q, req_d;
  logic [ERR_W-1:0]     cerr_q, cerr_d;
  logic [SIZE_BITS-1:0] csize_q, csize_d;
  logic [IDX_W-1:0]     ridx_q, ridx_d;
  logic [M_TDATA_W-1:0] m_data_q, m_data_d;

  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [ERR_W-1:0]     mem_werr;
  logic [SIZE_BITS-1:0] mem_wsize;
  logic [ERR_W-1:0]     mem_rerr;
  logic [SIZE_BITS-1:0] mem_rsize;
  pau_cmp_t             cmp;

  logic [CW-1:0]        new_cnt;
  logic [CW-1:0]        begin_idx;
  logic                 fin_ok;
  logic                 is_offer;
  logic                 acc;
  logic                 ovf;
  logic                 chg;
  logic                 rvalid;
  logic [M_TDATA_W-1:0] out_pack;

  pau_mem #(
    .ARCHIVE_DEPTH(ARCHIVE_DEPTH),
    .SIZE_BITS    (SIZE_BITS)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .werr_i (mem_werr),
    .wsize_i(mem_wsize),
    .raddr_i(addr_q),
    .rerr_o (mem_rerr),
    .rsize_o(mem_rsize)
  );

  pau_cmp #(
    .SIZE_BITS(SIZE_BITS)
  ) u_cmp (
    .cand_err_i (cerr_q),
    .cand_size_i(csize_q),
    .ent_err_i  (mem_rerr),
    .ent_size_i (mem_rsize),
    .res_o      (cmp)
  );

  assign new_cnt   = cnt_q - rem_q;
  assign is_offer  = (req_q == REQ_OFFER);
  assign acc       = is_offer && !stop_q && (new_cnt < DEPTH_C);
  assign ovf       = is_offer && !stop_q && (new_cnt >= DEPTH_C);
  assign chg       = acc || (rem_q != '0);
  assign rvalid    = !is_offer && (XW'(ridx_q) < XW'(cnt_q));
  assign fin_ok    = !m_valid_q || m_axis_tready_i;
  assign begin_idx = cmp.rej ? (CW'(idx_q) + CW'(1)) : '0;

  always_comb begin
    out_pack = '0;
    out_pack[M_ACC_LSB]                = acc;
    out_pack[M_REM_LSB +: OCNT_W]      = OCNT_W'(rem_q);
    out_pack[M_CHG_LSB]                = chg;
    out_pack[M_OVF_LSB]                = ovf;
    out_pack[M_CNT_LSB +: OCNT_W]      = OCNT_W'(new_cnt + CW'(acc));
    out_pack[M_RVAL_LSB]               = rvalid;
    out_pack[M_RERR_LSB +: ERR_W]      = rvalid ? mem_rerr : '0;
    out_pack[M_RSIZE_LSB +: SIZE_W]    = rvalid ? SIZE_W'(mem_rsize) : '0;
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    iss_d     = iss_q;
    pend_d    = pend_q;
    stop_d    = stop_q;
    m_valid_d = m_valid_q;
    addr_d    = addr_q;
    idx_d     = idx_q;
    wr_d      = wr_q;
    rem_d     = rem_q;
    req_d     = req_q;
    cerr_d    = cerr_q;
    csize_d   = csize_q;
    ridx_d    = ridx_q;
    m_data_d  = m_data_q;
    mem_we    = 1'b0;
    mem_waddr = wr_q;
    mem_werr  = mem_rerr;
    mem_wsize = mem_rsize;

    if (m_valid_q && m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          req_d   = pau_req_e'(s_axis_tuser_i);
          cerr_d  = s_axis_tdata_i[S_ERR_LSB +: ERR_W];
          csize_d = SIZE_BITS'(s_axis_tdata_i[S_SIZE_LSB +: SIZE_W]);
          ridx_d  = s_axis_tdata_i[S_IDX_LSB +: IDX_W];
          rem_d   = '0;
          stop_d  = 1'b0;
          pend_d  = 1'b0;
          if (pau_req_e'(s_axis_tuser_i) == REQ_READ) begin
            addr_d  = AW'(s_axis_tdata_i[S_IDX_LSB +: IDX_W]);
            state_d = ST_RD;
          end else if (cnt_q == '0) begin
            state_d = ST_FIN;
          end else begin
            addr_d  = AW'(cnt_q - CW'(1));
            iss_d   = 1'b1;
            state_d = ST_SCAN;
          end
        end
      end
      ST_RD: begin
        state_d = ST_FIN;
      end
      ST_SCAN: begin
        pend_d = iss_q;
        idx_d  = addr_q;
        if (iss_q) begin
          if (addr_q == '0) begin
            iss_d = 1'b0;
          end else begin
            addr_d = addr_q - AW'(1);
          end
        end
        if (pend_q && (cmp.rej || (idx_q == '0))) begin
          stop_d = cmp.rej;
          pend_d = 1'b0;
          if (begin_idx >= cnt_q) begin
            iss_d   = 1'b0;
            state_d = ST_FIN;
          end else begin
            addr_d  = AW'(begin_idx);
            wr_d    = AW'(begin_idx);
            iss_d   = 1'b1;
            state_d = ST_COMPACT;
          end
        end
      end
      ST_COMPACT: begin
        pend_d = iss_q;
        if (iss_q) begin
          if (CW'(addr_q) == (cnt_q - CW'(1))) begin
            iss_d = 1'b0;
          end else begin
            addr_d = addr_q + AW'(1);
          end
        end
        if (pend_q) begin
          if (cmp.rm) begin
            rem_d = rem_q + CW'(1);
          end else begin
            mem_we    = 1'b1;
            mem_waddr = wr_q;
            wr_d      = wr_q + AW'(1);
          end
        end
        if (!iss_q) begin
          pend_d  = 1'b0;
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (fin_ok) begin
          m_valid_d = 1'b1;
          m_data_d  = out_pack;
          cnt_d     = new_cnt + CW'(acc);
          if (acc) begin
            mem_we    = 1'b1;
            mem_waddr = AW'(new_cnt);
            mem_werr  = cerr_q;
            mem_wsize = csize_q;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      iss_q     <= 1'b0;
      pend_q    <= 1'b0;
      stop_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      iss_q     <= iss_d;
      pend_q    <= pend_d;
      stop_q    <= stop_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q   <= addr_d;
    idx_q    <= idx_d;
    wr_q     <= wr_d;
    rem_q    <= rem_d;
    req_q    <= req_d;
    cerr_q   <= cerr_d;
    csize_q  <= csize_d;
    ridx_q   <= ridx_d;
    m_data_q <= m_data_d;
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

endmodule

@@ rtl/pau_mem.sv @@
module pau_mem
  import pau_pkg::*;
#(
  parameter int ARCHIVE_DEPTH = ARCHIVE_DEPTH_DEF,
  parameter int SIZE_BITS     = SIZE_BITS_DEF,
  localparam int AW           = $clog2(ARCHIVE_DEPTH)
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AW-1:0]        waddr_i,
  input  logic [ERR_W-1:0]     werr_i,
  input  logic [SIZE_BITS-1:0] wsize_i,
  input  logic [AW-1:0]        raddr_i,
  output logic [ERR_W-1:0]     rerr_o,
  output logic [SIZE_BITS-1:0] rsize_o
);

  logic [ERR_W-1:0]     err_mem  [ARCHIVE_DEPTH];
  logic [SIZE_BITS-1:0] size_mem [ARCHIVE_DEPTH];
  logic [ERR_W-1:0]     rerr_q;
  logic [SIZE_BITS-1:0] rsize_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      err_mem[waddr_i]  <= werr_i;
      size_mem[waddr_i] <= wsize_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rerr_q  <= err_mem[raddr_i];
    rsize_q <= size_mem[raddr_i];
  end

  assign rerr_o  = rerr_q;
  assign rsize_o = rsize_q;

endmodule

@@ rtl/pau_cmp.sv @@
module pau_cmp
  import pau_pkg::*;
#(
  parameter int SIZE_BITS = SIZE_BITS_DEF
) (
  input  logic [ERR_W-1:0]     cand_err_i,
  input  logic [SIZE_BITS-1:0] cand_size_i,
  input  logic [ERR_W-1:0]     ent_err_i,
  input  logic [SIZE_BITS-1:0] ent_size_i,
  output pau_cmp_t             res_o
);

  logic err_le;
  logic size_le;
  logic err_ge;
  logic size_ge;

  assign err_le  = cand_err_i <= ent_err_i;
  assign size_le = cand_size_i <= ent_size_i;
  assign err_ge  = cand_err_i >= ent_err_i;
  assign size_ge = cand_size_i >= ent_size_i;

  always_comb begin
    res_o.eq  = (cand_err_i == ent_err_i) && (cand_size_i == ent_size_i);
    res_o.rm  = !res_o.eq && err_le && size_le;
    res_o.rej = res_o.eq || (err_ge && size_ge);
  end

endmodule

@@ rtl/pau_chk.sv @@
module pau_chk
  import pau_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid_i,
  input logic                 s_axis_tready_o,
  input logic                 m_axis_tvalid_o,
  input logic                 m_axis_tready_i,
  input logic [M_TDATA_W-1:0] m_axis_tdata_o
);

  logic acc;
  logic ovf;
  logic chg;
  logic rval;

  assign acc  = m_axis_tdata_o[M_ACC_LSB];
  assign ovf  = m_axis_tdata_o[M_OVF_LSB];
  assign chg  = m_axis_tdata_o[M_CHG_LSB];
  assign rval = m_axis_tdata_o[M_RVAL_LSB];

  // one transaction in work at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input taken while busy");

  a_accept_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && acc |-> chg && !ovf)
    else $error("stored candidate with bad flags");

  a_invalid_read_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !rval |->
      (m_axis_tdata_o[M_RERR_LSB +: ERR_W] == '0) &&
      (m_axis_tdata_o[M_RSIZE_LSB +: SIZE_W] == '0))
    else $error("read data not zero without valid read");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result changed");

endmodule

bind pareto_archive_update pau_chk u_pau_chk (.*);
